### rtl/ordered_list_insert_delete_top_assert.svh
// Assertion macros for the ordered list block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define OLID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define OLID_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define OLID_ASSERT(label, prop, msg)

`define OLID_ASSERT_NEVER(label, expr, msg)

`endif

`endif

### rtl/olid_pkg.sv
package olid_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_IGNORE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic insert_en;
        logic delete_en;
        logic read_en;
    } olid_ctrl_t;

endpackage

### rtl/ordered_list_insert_delete_top.sv
// Ordered list of up to CAPACITY signed values, kept packed front first in
// a row of cells that each hold one element and shift toward a neighbor.
// Command channel: cmd, value and position transfer on a rising edge with
// start high and busy low. cmd selects insert after position (0 = front),
// delete of the first element equal to value, or read of element position
// counted from 1; the fourth code does nothing and reports ok.
// Result channel: done is high for one cycle with status, read_value and
// length; the result transfers at the edge ending that cycle.
// Order: busy is high while the cells act on the command, and done rises
// in the cycle after, carrying the result registered in that busy cycle.
// Busy: busy is high for the cycle in which the cells compare and resolve
// the first-match chain, and no new command is taken while it is high.
// Status: ok, bad position, list full, or value not found; a failing
// command leaves the list unchanged. read_value is zero except on a good
// read. Reset empties the list at once; no clearing sweep is needed, since
// only occupied cells are ever read. The receiver cannot stall results.
module ordered_list_insert_delete_top #(
    parameter int CAPACITY   = olid_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = olid_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [olid_pkg::CMD_W-1:0]     cmd,
    input  logic signed [olid_pkg::VALUE_W-1:0] value,
    input  logic [olid_pkg::POS_W-1:0]     position,
    output logic                           done,
    output logic [olid_pkg::STATUS_W-1:0]  status,
    output logic signed [olid_pkg::VALUE_W-1:0] read_value,
    output logic [olid_pkg::LEN_W-1:0]     length
);
    import olid_pkg::*;

    `include "ordered_list_insert_delete_top_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic                  pending_reg;
    cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [IW-1:0]         pos_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic                  done_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [VALUE_W-1:0]    read_value_next;
    logic [LEN_W-1:0]      length_reg;

    logic                  accept;
    logic [63:0]           value_ext;
    logic [IW-1:0]         count_w;
    logic                  pos_past_end;
    logic                  is_full;
    logic                  read_bad;
    logic                  found;
    olid_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           rd_ext;

    logic [CAPACITY:0]     hit_chain;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

    assign accept    = start && !pending_reg;
    assign busy      = pending_reg;
    assign value_ext = 64'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            key_reg <= value_ext[DATA_WIDTH-1:0];
            pos_reg <= IW'(position);
        end
    end

    assign count_w      = IW'(count_reg);
    assign pos_past_end = pos_reg > count_w;
    assign is_full      = count_reg >= CAP_CNT;
    assign read_bad     = (pos_reg == '0) || pos_past_end;
    assign found        = hit_chain[CAPACITY];

    assign ctrl.insert_en = pending_reg && (cmd_reg == CMD_INSERT)
                            && !pos_past_end && !is_full;
    assign ctrl.delete_en = pending_reg && (cmd_reg == CMD_DELETE);
    assign ctrl.read_en   = pending_reg && (cmd_reg == CMD_READ) && !read_bad;

    assign hit_chain[0] = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = key_reg;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[k+1];
        end

        olid_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .INDEX      (k)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .pos        (pos_reg),
            .count      (count_w),
            .left_data  (left_d),
            .right_data (right_d),
            .hit_in     (hit_chain[k]),
            .hit_out    (hit_chain[k+1]),
            .data       (cell_data[k]),
            .read_data  (cell_rd[k])
        );
    end

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | cell_rd[i];
        end
    end

    assign rd_ext = 64'(signed'(rd_data));

    always_comb
    begin
        count_next      = count_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (pos_past_end)
                begin
                    status_next = ST_BAD_POS;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_MISSING;
                end
            end
            CMD_READ:
            begin
                if (read_bad)
                begin
                    status_next = ST_BAD_POS;
                end
                else
                begin
                    read_value_next = rd_ext[VALUE_W-1:0];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= pending_reg;
            if (pending_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pending_reg)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            length_reg     <= LEN_W'(count_next);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;

    `OLID_ASSERT(a_done_after_busy, done_reg |-> $past(pending_reg), "result without command")
    `OLID_ASSERT(a_busy_one_cycle, pending_reg |=> !pending_reg, "busy held too long")
    `OLID_ASSERT_NEVER(a_count_bound, count_reg > CAP_CNT, "element count above capacity")
    `OLID_ASSERT(a_length_matches, done_reg |-> (length_reg == LEN_W'(count_reg)), "length mismatch")
    `OLID_ASSERT_NEVER(a_count_idle, !$past(pending_reg) && (count_reg != $past(count_reg)), "count moved while idle")

endmodule

### rtl/olid_cell.sv
module olid_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                    clk,
    input  olid_pkg::olid_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]   key,
    input  logic [IW-1:0]           pos,
    input  logic [IW-1:0]           count,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    input  logic                    hit_in,
    output logic                    hit_out,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   read_data
);
    import olid_pkg::*;

    localparam logic [IW-1:0] IDX      = IW'(INDEX);
    localparam logic [IW-1:0] IDX_PLUS = IW'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  match;

    assign match     = (IDX < count) && (data_reg == key);
    assign hit_out   = hit_in | match;
    assign data      = data_reg;
    assign read_data = (ctrl.read_en && (pos == IDX_PLUS)) ? data_reg : '0;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert_en)
        begin
            if (IDX > pos)
            begin
                data_next = left_data;
            end
            else if (IDX == pos)
            begin
                data_next = key;
            end
        end
        else if (ctrl.delete_en && hit_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import olid_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int TARGET_ITEMS = 1750;

    typedef struct {
        status_t             status;
        logic signed [31:0]  read_value;
        logic [LEN_W-1:0]    length;
    } list_result_t;

    class list_tracker;
        logic signed [VALUE_W-1:0] elements[$];
        list_result_t              expected_results[$];
        int                        errors = 0;

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void note_command(cmd_t c, logic signed [VALUE_W-1:0] v,
                                   logic [POS_W-1:0] p);
            list_result_t r;
            int hit;
            r.status = ST_OK;
            r.read_value = '0;
            hit = -1;
            case (c)
                CMD_INSERT:
                begin
                    if (p > elements.size())
                        r.status = ST_BAD_POS;
                    else if (elements.size() >= LIST_DEPTH)
                        r.status = ST_FULL;
                    else
                        elements.insert(p, v);
                end
                CMD_DELETE:
                begin
                    foreach (elements[i])
                        if (hit < 0 && elements[i] == v)
                            hit = i;
                    if (hit < 0)
                        r.status = ST_MISSING;
                    else
                        elements.delete(hit);
                end
                CMD_READ:
                begin
                    if (p == 0 || p > elements.size())
                        r.status = ST_BAD_POS;
                    else
                        r.read_value = elements[p - 1];
                end
                default:
                begin
                end
            endcase
            r.length = LEN_W'(elements.size());
            expected_results.push_back(r);
        endfunction

        task check_result(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] rv,
                          logic [LEN_W-1:0] len);
            list_result_t e;
            if (expected_results.size() == 0)
            begin
                report("result with no command outstanding");
                return;
            end
            e = expected_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (rv !== e.read_value)
                report($sformatf("read_value %0d, expected %0d", rv, e.read_value));
            if (len !== e.length)
                report($sformatf("length %0d, expected %0d", len, e.length));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [CMD_W-1:0]            cmd = CMD_IGNORE;
    logic signed [VALUE_W-1:0]   value = '0;
    logic [POS_W-1:0]            position = '0;
    logic                        done;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   read_value;
    logic [LEN_W-1:0]            length;

    list_tracker tracker = new();
    int quiet_left = 0;

    ordered_list_insert_delete_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .length     (length)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(status, read_value, length);
    end

    function automatic int idle_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(30, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 6)) - 3;
        if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_cmd(cmd_t c, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        int gap;
        start <= 1'b1;
        cmd <= c;
        value <= v;
        position <= p;
        do
            @(posedge clk);
        while (busy);
        tracker.note_command(c, v, p);
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic directed_phase();
        logic signed [VALUE_W-1:0] seeds[6];
        int k;
        seeds = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 7, 7};
        send_cmd(CMD_READ, 0, 1);
        send_cmd(CMD_DELETE, 5, 0);
        send_cmd(CMD_INSERT, 9, 1);
        send_cmd(CMD_IGNORE, -1, 31);
        for (k = 0; k < LIST_DEPTH; k++)
            send_cmd(CMD_INSERT, (k < 6) ? seeds[k] : $urandom,
                     POS_W'((k * 7) % (k + 1)));
        send_cmd(CMD_INSERT, 3, 3);
        send_cmd(CMD_INSERT, 3, POS_W'(LIST_DEPTH + 1));
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, 0, 1);
        send_cmd(CMD_READ, 0, POS_W'(LIST_DEPTH));
        send_cmd(CMD_READ, 0, POS_W'(LIST_DEPTH + 1));
        send_cmd(CMD_DELETE, 7, 0);
        send_cmd(CMD_DELETE, 12345, 0);
    endtask

    task automatic random_phase(int count);
        int done_items;
        int r;
        int size;
        bit grow;
        cmd_t c;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0] p;
        done_items = 0;
        grow = 0;
        while (done_items < count)
        begin
            size = tracker.elements.size();
            if (size == LIST_DEPTH && $urandom_range(0, 3) == 0)
                grow = 0;
            else if (size == 0 && $urandom_range(0, 3) == 0)
                grow = 1;
            else if ($urandom_range(0, 49) == 0)
                grow = !grow;
            r = $urandom_range(0, 99);
            if (r < (grow ? 60 : 15))
                c = CMD_INSERT;
            else if (r < (grow ? 75 : 65))
                c = CMD_DELETE;
            else if (r < 95)
                c = CMD_READ;
            else
                c = CMD_IGNORE;
            v = pick_value();
            p = POS_W'($urandom_range(0, 31));
            case (c)
                CMD_INSERT:
                    if ($urandom_range(0, 99) < 92)
                        p = POS_W'($urandom_range(0, size));
                CMD_DELETE:
                    if (size > 0 && $urandom_range(0, 99) < 70)
                        v = tracker.elements[$urandom_range(0, size - 1)];
                CMD_READ:
                    if (size > 0 && $urandom_range(0, 99) < 85)
                        p = POS_W'($urandom_range(1, size));
                default:
                    v = $urandom;
            endcase
            send_cmd(c, v, p);
            done_items++;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_phase();
        random_phase(TARGET_ITEMS - 30);
        start <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.expected_results.size() != 0)
            tracker.report("results still outstanding at end of run");
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/olid_pkg.sv
rtl/olid_cell.sv
rtl/ordered_list_insert_delete_top.sv
bench/testbench.sv
